// ===== src/ltp_pkg.sv =====
package ltp_pkg;

    localparam int SIZE_BITS = 16;

    localparam int TS_W    = 33;
    localparam int BYTE_W  = 8;
    localparam int PKT_W   = 16;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 64;
    localparam int IDX_W   = 3;

    localparam logic [KIND_W-1:0] KIND_KEY   = 2'h0;
    localparam logic [KIND_W-1:0] KIND_PAINT = 2'h1;
    localparam logic [KIND_W-1:0] KIND_APP   = 2'h2;

    localparam logic [BYTE_W-1:0] TYPE_KEY   = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_PAINT = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_APP   = 8'h02;
    localparam logic [BYTE_W-1:0] KEY_LEN    = 8'd8;

    localparam logic REQ_PES  = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TYPE = 3'd1,
        PH_LEN  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TS_W-1:0]    pts;
        logic [VALUE_W-1:0] value;
    } event_t;

endpackage

// ===== src/ltp_core.sv =====
module ltp_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      req_type,
    input  logic [ltp_pkg::TS_W-1:0]   time_stamp,
    input  logic [ltp_pkg::BYTE_W-1:0] byte_value,
    input  logic                      packet_start,
    input  logic [ltp_pkg::PKT_W-1:0]  packet_bytes,
    output logic                      evt_valid,
    output ltp_pkg::event_t           evt
);
    import ltp_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]    entries_reg, entries_next;
    logic [SIZE_BITS-1:0] bytes_reg, bytes_next;
    logic [BYTE_W-1:0]    type_reg, type_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TS_W-1:0]      ts_reg, ts_next;

    logic [SIZE_BITS-1:0] total;
    logic [SIZE_BITS-1:0] bytes_len;
    logic [SIZE_BITS-1:0] bytes_key;
    logic [BYTE_W-1:0]    entries_dec;
    logic [VALUE_W-1:0]   acc_shift;

    assign total       = SIZE_BITS'(packet_bytes);
    assign bytes_len   = (bytes_reg >= SIZE_BITS'(2)) ? bytes_reg - SIZE_BITS'(2) : '0;
    assign bytes_key   = (bytes_reg >= SIZE_BITS'(1)) ? bytes_reg - SIZE_BITS'(1) : '0;
    assign entries_dec = entries_reg - BYTE_W'(1);
    assign acc_shift   = {acc_reg[VALUE_W-BYTE_W-1:0], byte_value};

    always_comb
    begin
        phase_next   = phase_reg;
        entries_next = entries_reg;
        bytes_next   = bytes_reg;
        type_next    = type_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        ts_next      = ts_reg;
        evt_valid    = 1'b0;
        evt.kind     = KIND_KEY;
        evt.pts      = ts_reg;
        evt.value    = '0;
        if (accept)
        begin
            if (req_type == REQ_PES)
            begin
                ts_next = time_stamp;
            end
            else if (packet_start)
            begin
                entries_next = byte_value;
                bytes_next   = (total == '0) ? '0 : total - SIZE_BITS'(1);
                acc_next     = '0;
                idx_next     = '0;
                phase_next   = (byte_value != '0 && bytes_next >= SIZE_BITS'(2))
                               ? PH_TYPE : PH_DONE;
            end
            else
            begin
                case (phase_reg)
                    PH_TYPE:
                    begin
                        type_next  = byte_value;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        bytes_next = bytes_len;
                        if (type_reg == TYPE_KEY && byte_value == KEY_LEN
                            && bytes_len >= SIZE_BITS'(KEY_LEN))
                        begin
                            acc_next   = '0;
                            idx_next   = '0;
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            if (type_reg == TYPE_PAINT || type_reg == TYPE_APP)
                            begin
                                evt_valid = 1'b1;
                                evt.kind  = KIND_W'(type_reg);
                            end
                            entries_next = entries_dec;
                            phase_next   = (entries_dec != '0 && bytes_len >= SIZE_BITS'(2))
                                           ? PH_TYPE : PH_DONE;
                        end
                    end
                    PH_KEY:
                    begin
                        acc_next   = acc_shift;
                        bytes_next = bytes_key;
                        if (idx_reg == IDX_W'(KEY_LEN - 8'd1))
                        begin
                            idx_next     = '0;
                            evt_valid    = 1'b1;
                            evt.kind     = KIND_KEY;
                            evt.value    = acc_shift;
                            entries_next = entries_dec;
                            phase_next   = (entries_dec != '0 && bytes_key >= SIZE_BITS'(2))
                                           ? PH_TYPE : PH_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            entries_reg <= '0;
            bytes_reg   <= '0;
            type_reg    <= '0;
            acc_reg     <= '0;
            idx_reg     <= '0;
            ts_reg      <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            entries_reg <= entries_next;
            bytes_reg   <= bytes_next;
            type_reg    <= type_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            ts_reg      <= ts_next;
        end
    end

`ifndef ASSERT_OFF
    a_evt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (phase_reg == PH_LEN || phase_reg == PH_KEY))
        else $error("event outside length or key phase");
    a_idx_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (phase_reg == PH_KEY))
        else $error("key byte index set outside key phase");
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.kind != KIND_KEY) |-> (evt.value == '0))
        else $error("nonzero value on non key event");
`endif

endmodule

// ===== src/ltp_obuf.sv =====
module ltp_obuf (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  ltp_pkg::event_t                push_evt,
    output logic                           space,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ltp_pkg::KIND_W-1:0]      event_kind,
    output logic [ltp_pkg::TS_W-1:0]        event_pts,
    output logic [ltp_pkg::VALUE_W-1:0]     event_value
);
    import ltp_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    event_t out_reg, out_next;
    event_t skid_reg, skid_next;
    logic   pop;

    assign pop         = out_valid_reg & out_ready;
    assign space       = ~skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign event_kind  = out_reg.kind;
    assign event_pts   = out_reg.pts;
    assign event_value = out_reg.value;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push && (!out_valid_reg || pop))
        begin
            out_next       = push_evt;
            out_valid_next = 1'b1;
        end
        else if (push)
        begin
            skid_next       = push_evt;
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef ASSERT_OFF
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output is empty");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");
    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid result not moved to output");
`endif

endmodule

// ===== src/latency_event_tlv_parser.sv =====
// Parses latency event TLV entries from a private data stream. One input transfer (a PES header
// time stamp or one payload byte) is taken per clock while in_ready is high; its state update
// happens in that cycle and any event it produces is registered in the output register or a skid
// stage. The two hold up to two events, so in_ready drops only while both hold untaken results.
module latency_event_tlv_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [ltp_pkg::TS_W-1:0]        time_stamp,
    input  logic [ltp_pkg::BYTE_W-1:0]      byte_value,
    input  logic                           packet_start,
    input  logic [ltp_pkg::PKT_W-1:0]       packet_bytes,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ltp_pkg::KIND_W-1:0]      event_kind,
    output logic [ltp_pkg::TS_W-1:0]        event_pts,
    output logic [ltp_pkg::VALUE_W-1:0]     event_value
);
    import ltp_pkg::*;

    logic   accept;
    logic   evt_valid;
    event_t evt;
    logic   space;

    assign in_ready = space;
    assign accept   = in_valid & space;

    ltp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .time_stamp   (time_stamp),
        .byte_value   (byte_value),
        .packet_start (packet_start),
        .packet_bytes (packet_bytes),
        .evt_valid    (evt_valid),
        .evt          (evt)
    );

    ltp_obuf u_obuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (evt_valid),
        .push_evt    (evt),
        .space       (space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .event_pts   (event_pts),
        .event_value (event_value)
    );

endmodule

// ===== test/tb_latency_event_tlv_parser.sv =====
`timescale 1ns / 100ps

import ltp_pkg::*;

typedef struct {
    logic              req;
    logic [TS_W-1:0]   ts;
    logic [BYTE_W-1:0] bval;
    logic              start;
    logic [PKT_W-1:0]  pbytes;
} stim_t;

class tlv_event_tracker;
    phase_t                phase;
    logic [BYTE_W-1:0]     entries_left;
    logic [SIZE_BITS-1:0]  bytes_left;
    logic [BYTE_W-1:0]     entry_type;
    logic [VALUE_W-1:0]    key_acc;
    logic [IDX_W-1:0]      key_idx;
    logic [TS_W-1:0]       last_ts;
    event_t                pending[$];
    int                    errors;
    int                    checked;

    function void clear();
        phase        = PH_IDLE;
        entries_left = '0;
        bytes_left   = '0;
        entry_type   = '0;
        key_acc      = '0;
        key_idx      = '0;
        last_ts      = '0;
        pending.delete();
        errors       = 0;
        checked      = 0;
    endfunction

    function void advance_entry();
        entries_left = entries_left - 1'b1;
        phase = (entries_left != 0 && bytes_left >= 2) ? PH_TYPE : PH_DONE;
    endfunction

    function void emit(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
        event_t ev;
        ev.kind  = kind;
        ev.pts   = last_ts;
        ev.value = value;
        pending.push_back(ev);
    endfunction

    function void note_input(stim_t it);
        logic [SIZE_BITS-1:0] total;
        total = SIZE_BITS'(it.pbytes);
        if (it.req == REQ_PES)
        begin
            last_ts = it.ts;
            return;
        end
        if (it.start)
        begin
            entries_left = it.bval;
            bytes_left   = (total == 0) ? '0 : total - 1'b1;
            key_acc      = '0;
            key_idx      = '0;
            phase = (entries_left != 0 && bytes_left >= 2) ? PH_TYPE : PH_DONE;
            return;
        end
        case (phase)
            PH_TYPE:
            begin
                entry_type = it.bval;
                phase      = PH_LEN;
            end
            PH_LEN:
            begin
                bytes_left = (bytes_left >= 2) ? bytes_left - 2'd2 : '0;
                if (entry_type == TYPE_KEY)
                begin
                    if (it.bval == KEY_LEN && bytes_left >= KEY_LEN)
                    begin
                        key_acc = '0;
                        key_idx = '0;
                        phase   = PH_KEY;
                    end
                    else
                        advance_entry();
                end
                else if (entry_type == TYPE_PAINT)
                begin
                    emit(KIND_PAINT, '0);
                    advance_entry();
                end
                else if (entry_type == TYPE_APP)
                begin
                    emit(KIND_APP, '0);
                    advance_entry();
                end
                else
                    advance_entry();
            end
            PH_KEY:
            begin
                key_acc    = {key_acc[VALUE_W-BYTE_W-1:0], it.bval};
                bytes_left = (bytes_left >= 1) ? bytes_left - 1'b1 : '0;
                if (key_idx == IDX_W'(KEY_LEN - 1))
                begin
                    key_idx = '0;
                    emit(KIND_KEY, key_acc);
                    advance_entry();
                end
                else
                    key_idx = key_idx + 1'b1;
            end
            default: ;
        endcase
    endfunction

    function void check_event(logic [KIND_W-1:0] kind, logic [TS_W-1:0] pts,
                              logic [VALUE_W-1:0] value);
        event_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected event, kind %0d pts %h value %h", $time, kind, pts, value);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (kind !== want.kind)
        begin
            $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, kind);
            errors++;
        end
        if (pts !== want.pts)
        begin
            $display("%0t: event_pts expected %h actual %h", $time, want.pts, pts);
            errors++;
        end
        if (value !== want.value)
        begin
            $display("%0t: event_value expected %h actual %h", $time, want.value, value);
            errors++;
        end
    endfunction
endclass

module tb_latency_event_tlv_parser;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 1250;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [TS_W-1:0]    time_stamp;
    logic [BYTE_W-1:0]  byte_value;
    logic               packet_start;
    logic [PKT_W-1:0]   packet_bytes;
    logic               out_valid;
    logic               out_ready;
    logic [KIND_W-1:0]  event_kind;
    logic [TS_W-1:0]    event_pts;
    logic [VALUE_W-1:0] event_value;

    tlv_event_tracker   events;
    logic               steady;
    int                 sent_items;
    int                 packets;
    int                 stall_cycles;

    latency_event_tlv_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .time_stamp   (time_stamp),
        .byte_value   (byte_value),
        .packet_start (packet_start),
        .packet_bytes (packet_bytes),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .event_pts    (event_pts),
        .event_value  (event_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);

    // transfer monitor and stall counter
    always @(posedge clk)
    begin
        stim_t it;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                it.req    = req_type;
                it.ts     = time_stamp;
                it.bval   = byte_value;
                it.start  = packet_start;
                it.pbytes = packet_bytes;
                events.note_input(it);
            end
            if (out_valid && out_ready)
                events.check_event(event_kind, event_pts, event_value);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("stalled for %0d cycles with %0d events outstanding",
                 stall_cycles, events.pending.size());
        $display("latency_event_tlv_parser verification failed");
        $finish;
    end

    function automatic logic [TS_W-1:0] rand_ts();
        logic [TS_W-1:0] v;
        v[31:0] = $urandom;
        v[32]   = 1'($urandom_range(0, 1));
        return v;
    endfunction

    task automatic push_item(input logic rq, input logic [TS_W-1:0] ts,
                             input logic [BYTE_W-1:0] b, input logic st,
                             input logic [PKT_W-1:0] pb);
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq;
        time_stamp   <= ts;
        byte_value   <= b;
        packet_start <= st;
        packet_bytes <= pb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_pes(input logic [TS_W-1:0] ts);
        push_item(REQ_PES, ts, BYTE_W'($urandom), 1'($urandom), PKT_W'($urandom));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        push_item(REQ_BYTE, rand_ts(), b, 1'b0, PKT_W'($urandom));
    endtask

    task automatic send_start(input logic [BYTE_W-1:0] cnt, input logic [PKT_W-1:0] pb);
        push_item(REQ_BYTE, rand_ts(), cnt, 1'b1, pb);
        packets++;
    endtask

    task automatic send_packet();
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] cnt;
        logic [BYTE_W-1:0] b;
        logic [PKT_W-1:0]  pb;
        int                entry_total;
        int                choice;
        int                keep;
        entry_total = $urandom_range(1, 6);
        for (int e = 0; e < entry_total; e++)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 40)
            begin
                body.push_back(TYPE_KEY);
                body.push_back(KEY_LEN);
                repeat (8) body.push_back(BYTE_W'($urandom));
            end
            else if (choice < 60)
            begin
                body.push_back(TYPE_PAINT);
                body.push_back(8'h00);
            end
            else if (choice < 80)
            begin
                body.push_back(TYPE_APP);
                body.push_back(8'h00);
            end
            else if (choice < 90)
            begin
                body.push_back(BYTE_W'($urandom_range(3, 255)));
                body.push_back(8'h00);
            end
            else
            begin
                // key press with a bad length byte
                b = BYTE_W'($urandom);
                if (b == KEY_LEN)
                    b = b + 1'b1;
                body.push_back(TYPE_KEY);
                body.push_back(b);
            end
        end
        cnt = ($urandom_range(0, 99) < 85) ? BYTE_W'(entry_total) : BYTE_W'($urandom);
        choice = $urandom_range(0, 99);
        if (choice < 80)
            pb = PKT_W'(body.size() + 1);
        else if (choice < 85)
            pb = '0;
        else if (choice < 92)
            pb = PKT_W'($urandom_range(1, body.size() + 1));
        else
            pb = PKT_W'($urandom);
        // sometimes the next packet starts early
        if ($urandom_range(0, 99) < 10)
        begin
            keep = $urandom_range(0, body.size());
            while (body.size() > keep)
                void'(body.pop_back());
        end
        send_start(cnt, pb);
        foreach (body[i])
        begin
            if ($urandom_range(0, 99) < 10)
                send_pes(rand_ts());
            send_byte(body[i]);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            push_item(1'($urandom), rand_ts(), BYTE_W'($urandom),
                      ($urandom_range(0, 7) == 0), PKT_W'($urandom));
        end
    endtask

    task automatic wait_for_events();
        in_valid <= 1'b0;
        @(posedge clk);
        while (events.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        events = new();
        events.clear();
        sent_items    = 0;
        packets       = 0;
        rst_n        <= 1'b0;
        steady       <= 1'b0;
        in_valid     <= 1'b0;
        req_type     <= REQ_PES;
        time_stamp   <= '0;
        byte_value   <= '0;
        packet_start <= 1'b0;
        packet_bytes <= '0;
        out_ready    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte before any packet
        send_byte(8'hAA);
        send_pes({TS_W{1'b1}});
        send_start(8'd3, {PKT_W{1'b1}});
        send_byte(TYPE_KEY);
        send_byte(KEY_LEN);
        repeat (8) send_byte(8'hFF);
        send_byte(TYPE_PAINT);
        send_byte(8'h00);
        // time stamp inside a packet
        send_pes('0);
        send_byte(TYPE_APP);
        send_byte(8'h00);
        // ignored after the entry count runs out
        send_byte(TYPE_PAINT);
        // empty packets
        send_start(8'd0, '0);
        send_byte(TYPE_PAINT);
        send_start(8'hFF, '0);
        send_byte(TYPE_APP);
        // key press with too few bytes left, then unknown type
        send_start(8'd2, 16'd5);
        send_byte(TYPE_KEY);
        send_byte(KEY_LEN);
        send_byte(8'hFF);
        send_byte(8'h00);
        // early packet start drops a partial key press
        send_start(8'd4, 16'd20);
        send_byte(TYPE_KEY);
        send_byte(KEY_LEN);
        send_byte(8'h12);
        send_byte(8'h34);
        send_start(8'd1, 16'd3);
        send_byte(TYPE_PAINT);
        send_byte(8'd5);
        wait_for_events();

        while (sent_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 80)
                send_packet();
            else
                send_noise();
            if (sent_items >= 450 && sent_items < 700)
                steady <= 1'b1;
            else
                steady <= 1'b0;
            if (sent_items >= 900 && packets % 17 == 0)
                wait_for_events();
        end

        wait_for_events();
        repeat (10) @(posedge clk);

        $display("sent %0d input transfers in %0d packets, checked %0d events",
                 sent_items, packets, events.checked);
        $display("mismatches %0d, events never seen %0d",
                 events.errors, events.pending.size());
        if (events.errors == 0 && events.pending.size() == 0)
            $display("latency_event_tlv_parser verification clean");
        else
            $display("latency_event_tlv_parser verification failed");
        $finish;
    end

endmodule

// ===== latency_event_tlv_parser.f =====
src/ltp_pkg.sv
src/ltp_core.sv
src/ltp_obuf.sv
src/latency_event_tlv_parser.sv
test/tb_latency_event_tlv_parser.sv
